// ===== design/gha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes for the generational handle allocator: word layouts,
// operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 10;
  localparam int VER_W    = 16;
  localparam int CNT_W    = 11;

  localparam logic [KIND_W-1:0] KIND_ALLOC    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VALIDATE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  handle_index;
    logic [VER_W-1:0]  handle_version;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    out_index;
    logic [VER_W-1:0]    out_version;
    logic [IDX_W-1:0]    dense_position;
    logic [CNT_W-1:0]    live_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_ALLOC_POP,
    ST_ALLOC_VER,
    ST_ALLOC_COMMIT,
    ST_CHECK,
    ST_REL_COMMIT,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

// ===== design/gha_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/generational_handle_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Versioned slot map: allocate, release and validate handles against a slot
// table, a free stack and a dense list of live handles, all in RAM.
// ----------------------------------------------------------------------------
// Steps: ISSUE answers table-full and spare-kind words itself; validate and
//   a rejected release pass ISSUE, CHECK; a release goes on to REL_COMMIT;
//   a new-slot allocate passes ISSUE, ALLOC_COMMIT; a reuse allocate passes
//   ISSUE, ALLOC_POP, ALLOC_VER, ALLOC_COMMIT. Every word ends in RESULT.
// Throughput: one word in flight; the next is taken the cycle after the
//   result is latched. The steps follow the chain of registered RAM reads
//   (free stack, then slot table; or slot table, then dense list).
// Reset: counters and control clear; no RAM sweep, data read from slots at
//   or above the open count is ignored.
module generational_handle_allocator_unit #(
  parameter int SLOT_COUNT   = 1024,
  parameter int VERSION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gha_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gha_pkg::out_item_t      out_item
);

  import gha_pkg::*;

  localparam int IW   = $clog2(SLOT_COUNT);
  localparam int CW   = $clog2(SLOT_COUNT + 1);
  localparam int VB   = VERSION_BITS;
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  state_t          state_r, state_nxt;
  in_item_t        op_r, op_nxt;
  logic [IW-1:0]   slot_r, slot_nxt;
  logic [VB-1:0]   ver_r, ver_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   free_r, free_nxt;
  logic [CW-1:0]   opened_r, opened_nxt;
  logic [CW-1:0]   live_r, live_nxt;
  out_item_t       res_r, res_nxt;
  out_item_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            slot_we, slot_re;
  logic [IW-1:0]   slot_waddr, slot_raddr;
  logic [VB:0]     slot_wdata, slot_rdata;
  logic            posm_we, posm_re;
  logic [IW-1:0]   posm_waddr, posm_raddr, posm_wdata, posm_rdata;
  logic            dense_we, dense_re;
  logic [IW-1:0]   dense_waddr, dense_raddr, dense_wdata, dense_rdata;
  logic            fstk_we, fstk_re;
  logic [IW-1:0]   fstk_waddr, fstk_raddr, fstk_wdata, fstk_rdata;

  logic            out_free;
  logic [VB-1:0]   ver_m;
  logic [VB-1:0]   ver_inc;
  logic            live_hit;

  gha_ram #(.WIDTH(VB + 1), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
  );

  gha_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_pos_ram (
    .clk(clk), .we(posm_we), .waddr(posm_waddr), .wdata(posm_wdata),
    .re(posm_re), .raddr(posm_raddr), .rdata(posm_rdata)
  );

  gha_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_dense_ram (
    .clk(clk), .we(dense_we), .waddr(dense_waddr), .wdata(dense_wdata),
    .re(dense_re), .raddr(dense_raddr), .rdata(dense_rdata)
  );

  gha_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_free_ram (
    .clk(clk), .we(fstk_we), .waddr(fstk_waddr), .wdata(fstk_wdata),
    .re(fstk_re), .raddr(fstk_raddr), .rdata(fstk_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign ver_m    = VB'(op_r.handle_version);
  assign ver_inc  = slot_rdata[VB-1:0] + VB'(1);
  assign live_hit = (ver_m != '0)
                 && (CMPW'(op_r.handle_index) < CMPW'(opened_r))
                 && slot_rdata[VB]
                 && (slot_rdata[VB-1:0] == ver_m);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_r      <= '0;
      opened_r    <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      opened_r    <= opened_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r   <= op_nxt;
    slot_r <= slot_nxt;
    ver_r  <= ver_nxt;
    pos_r  <= pos_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    ver_nxt       = ver_r;
    pos_nxt       = pos_r;
    free_nxt      = free_r;
    opened_nxt    = opened_r;
    live_nxt      = live_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    slot_we     = 1'b0;
    slot_waddr  = '0;
    slot_wdata  = '0;
    slot_re     = 1'b0;
    slot_raddr  = '0;
    posm_we     = 1'b0;
    posm_waddr  = '0;
    posm_wdata  = '0;
    posm_re     = 1'b0;
    posm_raddr  = '0;
    dense_we    = 1'b0;
    dense_waddr = '0;
    dense_wdata = '0;
    dense_re    = 1'b0;
    dense_raddr = '0;
    fstk_we     = 1'b0;
    fstk_waddr  = '0;
    fstk_wdata  = '0;
    fstk_re     = 1'b0;
    fstk_raddr  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_item;
          state_nxt = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        res_nxt.status         = STATUS_INVALID;
        res_nxt.out_index      = op_r.handle_index;
        res_nxt.out_version    = op_r.handle_version;
        res_nxt.dense_position = '0;
        res_nxt.live_count     = CNT_W'(live_r);
        priority if (op_r.kind == KIND_ALLOC) begin
          priority if (free_r != '0) begin
            fstk_re    = 1'b1;
            fstk_raddr = IW'(free_r - CW'(1));
            state_nxt  = ST_ALLOC_POP;
          end else if (opened_r < CW'(SLOT_COUNT)) begin
            slot_nxt  = IW'(opened_r);
            ver_nxt   = VB'(1);
            state_nxt = ST_ALLOC_COMMIT;
          end else begin
            res_nxt.status      = STATUS_FULL;
            res_nxt.out_index   = '0;
            res_nxt.out_version = '0;
            state_nxt           = ST_RESULT;
          end
        end else if (op_r.kind == KIND_RELEASE || op_r.kind == KIND_VALIDATE) begin
          slot_nxt   = IW'(op_r.handle_index);
          slot_re    = 1'b1;
          slot_raddr = IW'(op_r.handle_index);
          posm_re    = 1'b1;
          posm_raddr = IW'(op_r.handle_index);
          state_nxt  = ST_CHECK;
        end else begin
          state_nxt = ST_RESULT;
        end
      end

      ST_ALLOC_POP: begin
        slot_nxt   = fstk_rdata;
        slot_re    = 1'b1;
        slot_raddr = fstk_rdata;
        state_nxt  = ST_ALLOC_VER;
      end

      ST_ALLOC_VER: begin
        ver_nxt   = (ver_inc == '0) ? VB'(1) : ver_inc;
        state_nxt = ST_ALLOC_COMMIT;
      end

      ST_ALLOC_COMMIT: begin
        slot_we     = 1'b1;
        slot_waddr  = slot_r;
        slot_wdata  = {1'b1, ver_r};
        posm_we     = 1'b1;
        posm_waddr  = slot_r;
        posm_wdata  = IW'(live_r);
        dense_we    = 1'b1;
        dense_waddr = IW'(live_r);
        dense_wdata = slot_r;
        live_nxt    = live_r + CW'(1);
        if (free_r != '0) begin
          free_nxt = free_r - CW'(1);
        end else begin
          opened_nxt = opened_r + CW'(1);
        end
        res_nxt.status         = STATUS_OK;
        res_nxt.out_index      = IDX_W'(slot_r);
        res_nxt.out_version    = VER_W'(ver_r);
        res_nxt.dense_position = IDX_W'(live_r);
        res_nxt.live_count     = CNT_W'(live_r + CW'(1));
        state_nxt              = ST_RESULT;
      end

      ST_CHECK: begin
        ver_nxt = slot_rdata[VB-1:0];
        pos_nxt = posm_rdata;
        priority if (!live_hit) begin
          state_nxt = ST_RESULT;
        end else if (op_r.kind == KIND_VALIDATE) begin
          res_nxt.status         = STATUS_OK;
          res_nxt.out_version    = VER_W'(ver_m);
          res_nxt.dense_position = IDX_W'(posm_rdata);
          state_nxt              = ST_RESULT;
        end else begin
          dense_re    = 1'b1;
          dense_raddr = IW'(live_r - CW'(1));
          state_nxt   = ST_REL_COMMIT;
        end
      end

      ST_REL_COMMIT: begin
        dense_we    = 1'b1;
        dense_waddr = pos_r;
        dense_wdata = dense_rdata;
        if (dense_rdata != slot_r) begin
          posm_we    = 1'b1;
          posm_waddr = dense_rdata;
          posm_wdata = pos_r;
        end
        slot_we    = 1'b1;
        slot_waddr = slot_r;
        slot_wdata = {1'b0, ver_r};
        fstk_we    = 1'b1;
        fstk_waddr = IW'(free_r);
        fstk_wdata = slot_r;
        free_nxt   = free_r + CW'(1);
        live_nxt   = live_r - CW'(1);
        res_nxt.status         = STATUS_OK;
        res_nxt.out_version    = VER_W'(ver_r);
        res_nxt.dense_position = IDX_W'(pos_r);
        res_nxt.live_count     = CNT_W'(live_r - CW'(1));
        state_nxt              = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(live_r + free_r) == opened_r) && (live_r <= opened_r))
    else $error("live plus free count does not match opened slots");

  a_opened_bound: assert property (@(posedge clk) disable iff (!rst_n)
    opened_r <= CW'(SLOT_COUNT))
    else $error("opened slot count past table size");

  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC_COMMIT) |-> (live_r < CW'(SLOT_COUNT)))
    else $error("allocate commit with full dense list");

  a_release_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL_COMMIT) |-> (live_r != '0) && (free_r < CW'(SLOT_COUNT)))
    else $error("release commit with no live handle");

  a_result_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("pending result not latched into output");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational handle allocator. A directed
// table covers reset answers, null, stale, free and unopened handles, the
// spare kind code and swap-removal. Random traffic follows; most release
// and validate words in it carry live handles. A short release/allocate
// loop recycles one slot and bumps its version. An in-bench slot-map model
// predicts untyped words (typed rows carry theirs); a scoreboard checks
// each word in order, most of them under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import gha_pkg::*;

  localparam int SLOTS = 1024;
  localparam int LIMIT = 2000;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    in_item_t  w;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic [VER_W-1:0] ver_tbl [SLOTS];
  bit               occ     [SLOTS];
  logic [IDX_W-1:0] pos_tbl [SLOTS];
  logic [IDX_W-1:0] dense   [SLOTS];
  logic [IDX_W-1:0] free_stk[SLOTS];
  int               free_cnt;
  int               opened;
  int               live;

  out_item_t result_q[$];
  row_t      dir_rows[$];
  int        errors;
  int        stuck_cycles;
  int        src_idle_pct;
  int        dst_stall_pct;

  generational_handle_allocator_unit #(
    .SLOT_COUNT  (SLOTS),
    .VERSION_BITS(VER_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_live(logic [IDX_W-1:0] idx, logic [VER_W-1:0] ver);
    return ver != '0 && int'(idx) < opened && occ[idx] && ver_tbl[idx] == ver;
  endfunction

  function automatic out_item_t apply_op(in_item_t w);
    out_item_t        r;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] last;
    logic [VER_W-1:0] nv;
    bit               full;
    r = '0;
    r.status = STATUS_INVALID;
    r.out_index = w.handle_index;
    r.out_version = w.handle_version;
    full = 1'b0;
    if (w.kind == KIND_ALLOC) begin
      if (free_cnt > 0) begin
        free_cnt--;
        slot = free_stk[free_cnt];
        nv = ver_tbl[slot] + 1'b1;
        if (nv == '0) nv = VER_W'(1);
      end else if (opened < SLOTS) begin
        slot = IDX_W'(opened);
        opened++;
        nv = VER_W'(1);
      end else begin
        full = 1'b1;
      end
      if (full) begin
        r = '0;
        r.status = STATUS_FULL;
      end else begin
        ver_tbl[slot] = nv;
        occ[slot] = 1'b1;
        pos_tbl[slot] = IDX_W'(live);
        dense[live] = slot;
        live++;
        r.status = STATUS_OK;
        r.out_index = slot;
        r.out_version = nv;
        r.dense_position = IDX_W'(live - 1);
      end
    end else if (w.kind == KIND_RELEASE && is_live(w.handle_index, w.handle_version)) begin
      pos = pos_tbl[w.handle_index];
      last = dense[live - 1];
      dense[pos] = last;
      live--;
      if (last != w.handle_index) pos_tbl[last] = pos;
      occ[w.handle_index] = 1'b0;
      free_stk[free_cnt] = w.handle_index;
      free_cnt++;
      r.status = STATUS_OK;
      r.dense_position = pos;
    end else if (w.kind == KIND_VALIDATE && is_live(w.handle_index, w.handle_version)) begin
      r.status = STATUS_OK;
      r.dense_position = pos_tbl[w.handle_index];
    end
    r.live_count = CNT_W'(live);
    return r;
  endfunction

  function automatic in_item_t alloc_word();
    in_item_t w;
    w = in_item_t'($urandom);
    w.kind = KIND_ALLOC;
    return w;
  endfunction

  function automatic in_item_t live_word(logic [KIND_W-1:0] k);
    in_item_t         w;
    logic [IDX_W-1:0] idx;
    idx = dense[$urandom_range(live - 1)];
    w.kind = k;
    w.handle_index = idx;
    w.handle_version = ver_tbl[idx];
    return w;
  endfunction

  function automatic in_item_t pick_word();
    in_item_t         w;
    int               r;
    int               p;
    logic [IDX_W-1:0] idx;
    w = in_item_t'($urandom);
    r = $urandom_range(99);
    p = $urandom_range(99);
    if (r < 35) begin
      w.kind = KIND_ALLOC;
    end else if (r < 95) begin
      w.kind = (r < 65) ? KIND_RELEASE : KIND_VALIDATE;
      if (live > 0 && p < 75) begin
        w = live_word(w.kind);
      end else if (opened > 0 && p < 88) begin
        idx = IDX_W'($urandom_range(opened - 1));
        w.handle_index = idx;
        w.handle_version = (occ[idx] || p < 82) ? ver_tbl[idx] - 1'b1 : ver_tbl[idx];
      end else if (live > 0 && p < 93) begin
        w = live_word(w.kind);
        w.handle_version = '0;
      end
    end else begin
      w.kind = KIND_SPARE;
      if (live > 0 && p < 50) w = live_word(KIND_SPARE);
    end
    return w;
  endfunction

  function automatic string fmt(out_item_t o);
    return $sformatf("st=%0d idx=%0d ver=%0d pos=%0d live=%0d",
                     o.status, o.out_index, o.out_version, o.dense_position, o.live_count);
  endfunction

  task automatic add_row(logic [KIND_W-1:0] k, int idx, int ver, bit typed,
                         logic [STATUS_W-1:0] st, int oidx, int over, int pos, int cnt);
    row_t r;
    r.w.kind = k;
    r.w.handle_index = IDX_W'(idx);
    r.w.handle_version = VER_W'(ver);
    r.typed = typed;
    r.want.status = st;
    r.want.out_index = IDX_W'(oidx);
    r.want.out_version = VER_W'(over);
    r.want.dense_position = IDX_W'(pos);
    r.want.live_count = CNT_W'(cnt);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // enter and leave on a falling edge
  task automatic send_word(in_item_t w, bit typed, out_item_t want);
    out_item_t predicted;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_op(w);
    result_q.insert(result_q.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < dst_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        if (errors < 10) $display("unexpected word: %s", fmt(out_item));
        errors++;
      end else begin
        want = result_q.pop_front();
        if (out_item.status !== want.status || out_item.out_index !== want.out_index ||
            out_item.out_version !== want.out_version ||
            out_item.dense_position !== want.dense_position ||
            out_item.live_count !== want.live_count) begin
          if (errors < 10) $display("mismatch: want %s, got %s", fmt(want), fmt(out_item));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    in_item_t         w;
    logic [IDX_W-1:0] slot;
    errors = 0;
    stuck_cycles = 0;
    free_cnt = 0;
    opened = 0;
    live = 0;
    for (int i = 0; i < SLOTS; i++) begin
      ver_tbl[i] = '0;
      occ[i] = 1'b0;
    end
    src_idle_pct = 6;
    dst_stall_pct = 79;

    add_row(KIND_VALIDATE, 0, 1, 1'b1, STATUS_INVALID, 0, 1, 0, 0);
    add_row(KIND_RELEASE, 1023, 65535, 1'b1, STATUS_INVALID, 1023, 65535, 0, 0);
    add_row(KIND_SPARE, 1023, 65535, 1'b1, STATUS_INVALID, 1023, 65535, 0, 0);
    add_row(KIND_ALLOC, 0, 0, 1'b1, STATUS_OK, 0, 1, 0, 1);
    add_row(KIND_ALLOC, 1023, 65535, 1'b1, STATUS_OK, 1, 1, 1, 2);
    add_row(KIND_ALLOC, 0, 0, 1'b1, STATUS_OK, 2, 1, 2, 3);
    add_row(KIND_VALIDATE, 0, 1, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_VALIDATE, 1, 0, 1'b1, STATUS_INVALID, 1, 0, 0, 3);
    add_row(KIND_VALIDATE, 1, 2, 1'b1, STATUS_INVALID, 1, 2, 0, 3);
    add_row(KIND_VALIDATE, 3, 1, 1'b1, STATUS_INVALID, 3, 1, 0, 3);
    add_row(KIND_RELEASE, 0, 1, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_VALIDATE, 2, 1, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_RELEASE, 0, 1, 1'b1, STATUS_INVALID, 0, 1, 0, 2);
    add_row(KIND_VALIDATE, 0, 1, 1'b1, STATUS_INVALID, 0, 1, 0, 2);
    add_row(KIND_ALLOC, 0, 0, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_VALIDATE, 0, 1, 1'b1, STATUS_INVALID, 0, 1, 0, 3);
    add_row(KIND_RELEASE, 2, 1, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_RELEASE, 1, 1, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_VALIDATE, 0, 2, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_ALLOC, 0, 0, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_ALLOC, 0, 0, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_ALLOC, 0, 0, 1'b0, STATUS_OK, 0, 0, 0, 0);
    add_row(KIND_SPARE, 0, 2, 1'b1, STATUS_INVALID, 0, 2, 0, 4);
    add_row(KIND_RELEASE, 3, 65535, 1'b1, STATUS_INVALID, 3, 65535, 0, 4);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    repeat (280) send_word(pick_word(), 1'b0, '0);
    drain();

    src_idle_pct = 79;
    dst_stall_pct = 6;
    repeat (280) send_word(pick_word(), 1'b0, '0);
    drain();

    src_idle_pct = 0;
    dst_stall_pct = 0;
    // recycle one slot through release and allocate
    if (live == 0) send_word(alloc_word(), 1'b0, '0);
    w = live_word(KIND_RELEASE);
    repeat (8) begin
      send_word(w, 1'b0, '0);
      send_word(alloc_word(), 1'b0, '0);
      slot = dense[live - 1];
      w.handle_index = slot;
      w.handle_version = ver_tbl[slot];
    end
    w.kind = KIND_VALIDATE;
    send_word(w, 1'b0, '0);
    w.handle_version = '1;
    send_word(w, 1'b0, '0);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
